// ===== rtl/oef_pkg.sv =====
package oef_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned RATE_W    = 10;
  localparam int unsigned PARAM_W   = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned ALPHA_W   = 31;
  localparam int unsigned MUL_A_W   = 34;
  localparam int unsigned MUL_B_W   = 33;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;

  // 2*pi with 28 fraction bits
  localparam int unsigned TWO_PI_FRAC = 28;
  localparam logic [30:0] TWO_PI_Q28  = 31'd1686629713;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(30);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_RATE  = 2'd0,
    REG_MIN_CUTOFF   = 2'd1,
    REG_SPEED_GAIN   = 2'd2,
    REG_DERIV_CUTOFF = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_RESET  = 1'b1
  } action_e;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [MUL_P_W-1:0] v);
    logic signed [MUL_P_W-1:0] hi;
    logic signed [MUL_P_W-1:0] lo;
    hi = MUL_P_W'(33'sh0_7FFF_FFFF);
    lo = -MUL_P_W'(34'sh0_8000_0000);
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/oef_in_if.sv =====
interface oef_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [oef_pkg::COORD_W-1:0] x_coord;
  logic signed [oef_pkg::COORD_W-1:0] y_coord;

  modport source (output valid, action, x_coord, y_coord, input ready);
  modport sink   (input valid, action, x_coord, y_coord, output ready);
endinterface

// ===== rtl/oef_out_if.sv =====
interface oef_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [oef_pkg::COORD_W-1:0] x_smooth;
  logic signed [oef_pkg::COORD_W-1:0] y_smooth;

  modport source (output valid, x_smooth, y_smooth, input ready);
  modport sink   (input valid, x_smooth, y_smooth, output ready);
endinterface

// ===== rtl/one_euro_filter_2d.sv =====
// One-euro adaptive smoothing of a 2-D cursor position (signed fixed point).
// Input channel in_i carries action, x_coord, y_coord; a transfer with action
// set clears the seeded flag and yields no result. Output channel out_o
// carries x_smooth, y_smooth. Registers are written through cfg_we_i /
// cfg_idx_i / cfg_data_i; the user must write them only while the block
// is idle, as the block itself does not enforce it.
// A reset transfer yields no result and leaves the input ready. The first
// sample after reset passes through to out_o via S_OUT. A filtered sample
// runs one 31-step restoring division for the speed smoothing factor, then
// per axis five multiplier passes and another 31-step division, on the
// single shared multiplier and the bit-serial divider; the input is not
// ready while a sample is at work, so the next input is taken only after
// the result has gone to the output register.
// The result sits in an output register, so the next input transfer is
// taken while a finished result waits; when the receiver stalls, a
// following result holds in its final state until the register frees up.
// Reset clears the seeded flag, the stored position and speed, and loads
// the register defaults (30 Hz, min cutoff 1.0, gain 0.02, deriv cutoff 1.0).
module one_euro_filter_2d #(
  parameter int unsigned FRAC_BITS = oef_pkg::FRAC_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [oef_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [oef_pkg::PARAM_W-1:0]          cfg_data_i,
  oef_in_if.sink                               in_i,
  oef_out_if.source                            out_o
);

  localparam int unsigned CW     = oef_pkg::COORD_W;
  localparam int unsigned PW     = oef_pkg::MUL_P_W;
  localparam int unsigned RATE_SH = FRAC_BITS + oef_pkg::TWO_PI_FRAC;
  localparam logic [oef_pkg::PARAM_W-1:0] ONE_Q = oef_pkg::PARAM_W'(1 << FRAC_BITS);
  localparam logic [oef_pkg::PARAM_W-1:0] GAIN_RESET =
    oef_pkg::PARAM_W'(((1 << FRAC_BITS) * 2 + 50) / 100);

  typedef enum logic [3:0] {
    S_IDLE, S_W_MUL, S_DIV_INIT, S_DIV, S_SPEED_MUL, S_SPEED_SAT, S_ES_MUL,
    S_ES_ADD, S_CUT_MUL, S_CUT_ADD, S_POS_MUL, S_POS_ADD, S_OUT
  } state_e;

  state_e state_q;

  // registers
  logic [oef_pkg::RATE_W-1:0]  rate_q;
  logic [oef_pkg::PARAM_W-1:0] min_cut_q, gain_q, dcut_q;

  // filter state
  logic                 seeded_q;
  logic signed [CW-1:0] lp_q [2];
  logic signed [CW-1:0] ls_q [2];

  // work registers
  logic signed [CW-1:0] x_q, y_q, speed_q, es_q;
  logic [CW-1:0]        cut_q;
  logic                 axis_q, phase_q;
  logic signed [PW-1:0] mul_q;
  logic [63:0]          rem_q, den_q;
  logic [oef_pkg::ALPHA_W-1:0] quo_q, alpha_d_q, alpha_q;
  logic [4:0]           cnt_q;
  logic signed [CW-1:0] res_q [2];

  logic                 out_valid_q;
  logic signed [CW-1:0] out_x_q, out_y_q;

  // shared multiplier operands
  logic signed [oef_pkg::MUL_A_W-1:0] mul_a;
  logic signed [oef_pkg::MUL_B_W-1:0] mul_b;
  logic signed [CW-1:0] xin, lp_sel, ls_sel;
  logic signed [CW:0]   es_ext, mag;
  logic [CW+24:0]       cut_sum;
  logic [63:0]          rem_sh, w_val;
  logic                 div_take;

  assign xin    = axis_q ? y_q : x_q;
  assign lp_sel = lp_q[axis_q];
  assign ls_sel = ls_q[axis_q];
  assign es_ext = (CW+1)'(es_q);
  assign mag    = es_q[CW-1] ? -es_ext : es_ext;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_W_MUL: begin
        mul_a = oef_pkg::MUL_A_W'({1'b0, cut_q});
        mul_b = oef_pkg::MUL_B_W'({1'b0, oef_pkg::TWO_PI_Q28});
      end
      S_SPEED_MUL: begin
        mul_a = oef_pkg::MUL_A_W'(xin) - oef_pkg::MUL_A_W'(lp_sel);
        mul_b = oef_pkg::MUL_B_W'({1'b0, rate_q});
      end
      S_ES_MUL: begin
        mul_a = oef_pkg::MUL_A_W'(speed_q) - oef_pkg::MUL_A_W'(ls_sel);
        mul_b = oef_pkg::MUL_B_W'({1'b0, alpha_d_q});
      end
      S_CUT_MUL: begin
        mul_a = oef_pkg::MUL_A_W'({1'b0, gain_q});
        mul_b = mag;
      end
      S_POS_MUL: begin
        mul_a = oef_pkg::MUL_A_W'(xin) - oef_pkg::MUL_A_W'(lp_sel);
        mul_b = oef_pkg::MUL_B_W'({1'b0, alpha_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // cutoff = minimum cutoff + gain*|speed| >> FRAC
  assign cut_sum = (CW+25)'(min_cut_q) + (CW+25)'(mul_q[55:0] >> FRAC_BITS);

  // one restoring-division step
  assign rem_sh   = {rem_q[62:0], 1'b0};
  assign div_take = rem_q[63] || (rem_sh >= den_q);
  assign w_val    = mul_q[63:0];

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.x_smooth = out_x_q;
  assign out_o.y_smooth = out_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rate_q      <= oef_pkg::RATE_RESET;
      min_cut_q   <= ONE_Q;
      gain_q      <= GAIN_RESET;
      dcut_q      <= ONE_Q;
      seeded_q    <= 1'b0;
      lp_q[0]     <= '0;
      lp_q[1]     <= '0;
      ls_q[0]     <= '0;
      ls_q[1]     <= '0;
      axis_q      <= 1'b0;
      phase_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (oef_pkg::cfg_reg_e'(cfg_idx_i))
          oef_pkg::REG_SAMPLE_RATE:
            rate_q <= (cfg_data_i[oef_pkg::RATE_W-1:0] == '0) ?
                      oef_pkg::RATE_W'(1) : cfg_data_i[oef_pkg::RATE_W-1:0];
          oef_pkg::REG_MIN_CUTOFF:   min_cut_q <= cfg_data_i;
          oef_pkg::REG_SPEED_GAIN:   gain_q    <= cfg_data_i;
          oef_pkg::REG_DERIV_CUTOFF: dcut_q    <= cfg_data_i;
          default: ;
        endcase
      end

      // drop the valid flag after a transfer unless a new result refills it
      if (out_valid_q && out_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      mul_q <= mul_a * mul_b;

      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            if (in_i.action == oef_pkg::ACT_RESET) begin
              seeded_q <= 1'b0;
            end else if (!seeded_q) begin
              // seed: pass through
              lp_q[0]  <= in_i.x_coord;
              lp_q[1]  <= in_i.y_coord;
              ls_q[0]  <= '0;
              ls_q[1]  <= '0;
              res_q[0] <= in_i.x_coord;
              res_q[1] <= in_i.y_coord;
              seeded_q <= 1'b1;
              state_q  <= S_OUT;
            end else begin
              x_q     <= in_i.x_coord;
              y_q     <= in_i.y_coord;
              cut_q   <= CW'(dcut_q);
              phase_q <= 1'b0;
              axis_q  <= 1'b0;
              state_q <= S_W_MUL;
            end
          end
        end
        S_W_MUL: state_q <= S_DIV_INIT;
        S_DIV_INIT: begin
          rem_q   <= w_val;
          den_q   <= w_val + (64'(rate_q) << RATE_SH);
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= div_take ? rem_sh - den_q : rem_sh;
          quo_q <= {quo_q[oef_pkg::ALPHA_W-2:0], div_take};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(oef_pkg::ALPHA_W - 1)) begin
            if (!phase_q) begin
              alpha_d_q <= {quo_q[oef_pkg::ALPHA_W-2:0], div_take};
              state_q   <= S_SPEED_MUL;
            end else begin
              alpha_q <= {quo_q[oef_pkg::ALPHA_W-2:0], div_take};
              state_q <= S_POS_MUL;
            end
          end
        end
        S_SPEED_MUL: state_q <= S_SPEED_SAT;
        S_SPEED_SAT: begin
          speed_q <= oef_pkg::sat32(mul_q);
          state_q <= S_ES_MUL;
        end
        S_ES_MUL: state_q <= S_ES_ADD;
        S_ES_ADD: begin
          es_q         <= oef_pkg::sat32(PW'(ls_sel) + (mul_q >>> oef_pkg::ALPHA_W));
          ls_q[axis_q] <= oef_pkg::sat32(PW'(ls_sel) + (mul_q >>> oef_pkg::ALPHA_W));
          state_q      <= S_CUT_MUL;
        end
        S_CUT_MUL: state_q <= S_CUT_ADD;
        S_CUT_ADD: begin
          // saturate cutoff to the unsigned 32-bit range
          cut_q   <= (cut_sum[CW+24:CW] != '0) ? '1 : cut_sum[CW-1:0];
          phase_q <= 1'b1;
          state_q <= S_W_MUL;
        end
        S_POS_MUL: state_q <= S_POS_ADD;
        S_POS_ADD: begin
          lp_q[axis_q]  <= oef_pkg::sat32(PW'(lp_sel) + (mul_q >>> oef_pkg::ALPHA_W));
          res_q[axis_q] <= oef_pkg::sat32(PW'(lp_sel) + (mul_q >>> oef_pkg::ALPHA_W));
          if (!axis_q) begin
            axis_q  <= 1'b1;
            state_q <= S_SPEED_MUL;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_x_q     <= res_q[0];
            out_y_q     <= res_q[1];
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TWOPI = 1686629713;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [oef_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [oef_pkg::PARAM_W-1:0] cfg_data_i = '0;

  oef_in_if in_ch ();
  oef_out_if out_ch ();

  one_euro_filter_2d uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always #10 clk_i = ~clk_i;

  typedef struct packed {
    logic signed [31:0] xs;
    logic signed [31:0] ys;
  } smooth_pos_t;

  typedef struct {
    oef_pkg::action_e act;
    logic signed [31:0] x;
    logic signed [31:0] y;
    bit known;      // expected value typed in below
    smooth_pos_t pos;
  } stim_row_t;

  // predictor state and shadow registers
  logic [9:0] rate_hz;
  logic [23:0] min_cut, gain, d_cut;
  bit is_seeded;
  logic signed [31:0] prev_pos [2];
  logic signed [31:0] prev_spd [2];

  smooth_pos_t pos_expect_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;

  function automatic logic signed [31:0] clamp32(logic signed [95:0] v);
    if (v > 96'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -96'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [30:0] alpha_of(logic [31:0] c);
    logic [63:0] w, den, rem;
    logic [30:0] q;
    bit top;
    w = 64'(c) * 64'(TWOPI);
    den = w + (64'(rate_hz == 0 ? 10'd1 : rate_hz) << 44);
    rem = w;
    q = '0;
    for (int i = 0; i < 31; i++) begin
      top = rem[63];
      rem = rem << 1;
      q = q << 1;
      if (top || rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // arithmetic shift of a signed value is a floor division
  function automatic logic signed [31:0] lowpass(logic signed [31:0] in_v,
                                                 logic signed [31:0] prv,
                                                 logic [30:0] a);
    logic signed [95:0] prod;
    prod = (96'(in_v) - 96'(prv)) * $signed({65'd0, a});
    return clamp32(96'(prv) + (prod >>> 31));
  endfunction

  function automatic logic signed [31:0] filter_axis(int k, logic signed [31:0] v);
    logic signed [95:0] d;
    logic signed [31:0] spd, es, ex;
    logic [63:0] mag, cut;
    d = (96'(v) - 96'(prev_pos[k])) * $signed(96'(rate_hz == 0 ? 10'd1 : rate_hz));
    spd = clamp32(d);
    es = lowpass(spd, prev_spd[k], alpha_of({8'd0, d_cut}));
    mag = es < 0 ? 64'(-64'(es)) : 64'(es);
    cut = 64'(min_cut) + ((64'(gain) * mag) >> 16);
    if (cut > 64'hFFFF_FFFF) cut = 64'hFFFF_FFFF;
    ex = lowpass(v, prev_pos[k], alpha_of(cut[31:0]));
    prev_pos[k] = ex;
    prev_spd[k] = es;
    return ex;
  endfunction

  // advance the predictor by one accepted transfer
  task automatic predict_position(oef_pkg::action_e act, logic signed [31:0] x,
                                  logic signed [31:0] y);
    smooth_pos_t p;
    if (act == oef_pkg::ACT_RESET) begin
      is_seeded = 1'b0;
      return;
    end
    if (!is_seeded) begin
      prev_pos[0] = x;
      prev_pos[1] = y;
      prev_spd[0] = 0;
      prev_spd[1] = 0;
      is_seeded = 1'b1;
      p.xs = x;
      p.ys = y;
    end else begin
      p.xs = filter_axis(0, x);
      p.ys = filter_axis(1, y);
    end
    pos_expect_q = {pos_expect_q, p};
  endtask

  task automatic write_reg(oef_pkg::cfg_reg_e idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      oef_pkg::REG_SAMPLE_RATE: rate_hz = val[9:0];
      oef_pkg::REG_MIN_CUTOFF: min_cut = val;
      oef_pkg::REG_SPEED_GAIN: gain = val;
      default: d_cut = val;
    endcase
  endtask

  // offer one item at the falling edge, hold until the transfer
  task automatic send_item(oef_pkg::action_e act, logic signed [31:0] x,
                           logic signed [31:0] y);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_ch.valid = 1'b1;
    in_ch.action = act;
    in_ch.x_coord = x;
    in_ch.y_coord = y;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_position(act, x, y);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  // wait for all results, then let a reset transfer settle
  task automatic drain();
    while (pos_expect_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // receiver: random stall, optional long hold-off
  always @(negedge clk_i) begin
    out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // check every result transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pos_expect_q.size() == 0) begin
        $error("result with nothing expected: x_smooth=%0d y_smooth=%0d",
               out_ch.x_smooth, out_ch.y_smooth);
        errors++;
      end else begin
        smooth_pos_t e;
        e = pos_expect_q[0];
        pos_expect_q.delete(0);
        if (out_ch.x_smooth !== e.xs) begin
          $error("x_smooth expected %0d actual %0d", e.xs, out_ch.x_smooth);
          errors++;
        end
        if (out_ch.y_smooth !== e.ys) begin
          $error("y_smooth expected %0d actual %0d", e.ys, out_ch.y_smooth);
          errors++;
        end
      end
    end
  end

  // directed rows; typed-in results only where obvious
  stim_row_t rows[] = '{
    '{oef_pkg::ACT_SAMPLE, 32'sh0001_0000, -32'sh0002_0000, 1,
      '{32'sh0001_0000, -32'sh0002_0000}},
    '{oef_pkg::ACT_SAMPLE, 32'sh0001_0000, -32'sh0002_0000, 1,
      '{32'sh0001_0000, -32'sh0002_0000}},
    '{oef_pkg::ACT_SAMPLE, 32'sh0003_8000, 32'sh0000_4000, 0, '{0, 0}},
    '{oef_pkg::ACT_RESET, 32'sh1234_5678, 32'sh0, 0, '{0, 0}},
    '{oef_pkg::ACT_SAMPLE, 32'sh7FFF_FFFF, 32'sh8000_0000, 1,
      '{32'sh7FFF_FFFF, 32'sh8000_0000}},
    '{oef_pkg::ACT_SAMPLE, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, '{0, 0}},
    '{oef_pkg::ACT_SAMPLE, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, '{0, 0}},
    '{oef_pkg::ACT_SAMPLE, 32'shFFFF_FFFF, 32'sh0, 0, '{0, 0}},
    '{oef_pkg::ACT_RESET, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 0, '{0, 0}},
    '{oef_pkg::ACT_RESET, 32'sh0, 32'sh0, 0, '{0, 0}},
    '{oef_pkg::ACT_SAMPLE, 32'sh0, 32'sh0, 1, '{0, 0}},
    '{oef_pkg::ACT_SAMPLE, 32'sh0, 32'sh0, 1, '{0, 0}},
    '{oef_pkg::ACT_SAMPLE, 32'sh0010_0000, -32'sh0010_0000, 0, '{0, 0}},
    '{oef_pkg::ACT_SAMPLE, 32'sh0020_0000, -32'sh0020_0000, 0, '{0, 0}},
    '{oef_pkg::ACT_SAMPLE, 32'sh5555_5555, 32'shAAAA_AAAA, 0, '{0, 0}}
  };

  // keep the random walk near the last position so the filter stays busy
  task automatic random_burst(int n);
    logic signed [31:0] cx, cy;
    cx = $urandom;
    cy = $urandom;
    for (int i = 0; i < n; i++) begin
      int r;
      r = $urandom_range(99);
      if (r < 4) begin
        send_item(oef_pkg::ACT_RESET, $urandom, $urandom);
      end else if (r < 12) begin
        cx = $urandom;
        cy = $urandom;
        send_item(oef_pkg::ACT_SAMPLE, cx, cy);
      end else begin
        cx = cx + $signed(32'($urandom_range(65535 * 8)) - 32'sd262140);
        cy = cy + $signed(32'($urandom_range(65535 * 8)) - 32'sd262140);
        send_item(oef_pkg::ACT_SAMPLE, cx, cy);
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = oef_pkg::ACT_SAMPLE;
    in_ch.x_coord = '0;
    in_ch.y_coord = '0;
    out_ch.ready = 1'b0;
    rate_hz = 10'd30;
    min_cut = 24'd65536;
    gain = 24'd1311;
    d_cut = 24'd65536;
    is_seeded = 1'b0;
    prev_pos = '{0, 0};
    prev_spd = '{0, 0};
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at reset defaults
    foreach (rows[i]) begin
      if (rows[i].known) begin
        smooth_pos_t p;
        send_item(rows[i].act, rows[i].x, rows[i].y);
        p = pos_expect_q[$];
        if (p != rows[i].pos) begin
          $error("x_smooth/y_smooth table expected %0d/%0d predicted %0d/%0d",
                 rows[i].pos.xs, rows[i].pos.ys, p.xs, p.ys);
          errors++;
        end
      end else begin
        send_item(rows[i].act, rows[i].x, rows[i].y);
      end
    end
    drain();

    // phases across register settings and idling mixes
    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 71; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 71; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      case (ph)
        0: ;
        1: begin
          write_reg(oef_pkg::REG_SAMPLE_RATE, 24'd1000);
          write_reg(oef_pkg::REG_MIN_CUTOFF, 24'hFF_FFFF);
          write_reg(oef_pkg::REG_SPEED_GAIN, 24'hFF_FFFF);
          write_reg(oef_pkg::REG_DERIV_CUTOFF, 24'hFF_FFFF);
        end
        2: begin
          write_reg(oef_pkg::REG_SAMPLE_RATE, 24'd1);
          write_reg(oef_pkg::REG_MIN_CUTOFF, 24'd1);
          write_reg(oef_pkg::REG_SPEED_GAIN, 24'd0);
          write_reg(oef_pkg::REG_DERIV_CUTOFF, 24'd1);
        end
        3: write_reg(oef_pkg::REG_SAMPLE_RATE, 24'd0); // zero rate acts as 1 Hz
        default: begin
          write_reg(oef_pkg::REG_SAMPLE_RATE, $urandom_range(1000, 1));
          write_reg(oef_pkg::REG_MIN_CUTOFF, $urandom_range(24'hFF_FFFF, 1));
          write_reg(oef_pkg::REG_SPEED_GAIN, $urandom_range(24'hFF_FFFF));
          write_reg(oef_pkg::REG_DERIV_CUTOFF, $urandom_range(24'hFF_FFFF, 1));
        end
      endcase
      random_burst(200);
      if (ph == 4) begin
        // hold the receiver off for a long stretch while items keep coming
        fork
          begin
            hold_off = 1'b1;
            repeat (600) @(negedge clk_i);
            hold_off = 1'b0;
          end
          random_burst(8);
        join
      end
      drain();
    end

    if (errors == 0 && pos_expect_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
